// ===== src/tbcs_pkg.sv =====
package tbcs_pkg;

   // Queue depth and the widths that follow from it.
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // Fixed field widths.
   localparam int ID_W   = 4;
   localparam int REM_W  = 10;
   localparam int TIME_W = 16;

   // Commands to the ready queue.
   localparam logic [2:0] Q_NOP     = 3'd0;
   localparam logic [2:0] Q_INSERT  = 3'd1;
   localparam logic [2:0] Q_DROP    = 3'd2;
   localparam logic [2:0] Q_ROTATE  = 3'd3;
   localparam logic [2:0] Q_SETHEAD = 3'd4;

   // Item operations.
   typedef enum logic {OP_ARRIVE = 1'b0, OP_TICK = 1'b1} sched_op_type;

   // Scheduling policies; the last code behaves as first in first out.
   typedef enum logic [1:0] {
      POL_FIFO = 2'd0, POL_SRTF = 2'd1, POL_RR = 2'd2, POL_ALIAS_FIFO = 2'd3
   } policy_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [REM_W-1:0] rem;
   } entry_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [IDX_W-1:0] pos;
      entry_type        data;
   } queue_cmd_type;

endpackage

// ===== src/tbcs_alu.sv =====
module tbcs_alu (
   input  logic [tbcs_pkg::TIME_W-1:0] opa,
   input  logic [tbcs_pkg::TIME_W-1:0] opb,
   output logic [tbcs_pkg::TIME_W-1:0] diff,
   output logic                        borrow
);
   import tbcs_pkg::*;

   // Shared subtractor: the borrow flags opa < opb, and subtracting all ones adds one.
   assign {borrow, diff} = {1'b0, opa} - {1'b0, opb};

endmodule

// ===== src/tbcs_queue.sv =====
module tbcs_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  tbcs_pkg::queue_cmd_type      cmd,
   input  logic [tbcs_pkg::IDX_W-1:0]   rd_idx,
   output tbcs_pkg::entry_type          head,
   output tbcs_pkg::entry_type          rd_entry,
   output logic [tbcs_pkg::CNT_W-1:0]   count
);
   import tbcs_pkg::*;

   entry_type        entry_ff [MAX_TASKS];
   entry_type        entry_in [MAX_TASKS];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] last_pos;

   assign last_pos = count_ff - CNT_W'(1);

   // Each cell picks its next value from itself, a neighbor, the head or the new item.
   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;

      if (g == 0) begin : g_first
         assign prev_e = entry_ff[0];
      end else begin : g_prev
         assign prev_e = entry_ff[g-1];
      end

      if (g == MAX_TASKS - 1) begin : g_last
         assign next_e = entry_ff[g];
      end else begin : g_next
         assign next_e = entry_ff[g+1];
      end

      always_comb begin
         entry_in[g] = entry_ff[g];
         case (cmd.op)
            Q_INSERT: begin
               if (IDX_W'(g) == cmd.pos) begin
                  entry_in[g] = cmd.data;
               end else if (IDX_W'(g) > cmd.pos) begin
                  entry_in[g] = prev_e;
               end
            end
            Q_DROP: begin
               entry_in[g] = next_e;
            end
            Q_ROTATE: begin
               if (CNT_W'(g) == last_pos) begin
                  entry_in[g] = entry_ff[0];
               end else if (CNT_W'(g) < last_pos) begin
                  entry_in[g] = next_e;
               end
            end
            Q_SETHEAD: begin
               if (g == 0) begin
                  entry_in[g].rem = cmd.data.rem;
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         entry_ff[g] <= entry_in[g];
      end
   end

   // Fill count of the queue.
   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         Q_INSERT: count_in = count_ff + CNT_W'(1);
         Q_DROP:   count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head     = entry_ff[0];
   assign rd_entry = entry_ff[rd_idx];
   assign count    = count_ff;

endmodule

// ===== src/tick_based_cpu_scheduler_unit.sv =====
// An arrival passes the arrival and insert states (SRTF: a scan state in between, one
// queue entry per cycle through the shared subtractor); a full queue rejects it in the
// arrival state. A tick passes the rotate and run states, then turnaround and wait if
// its task finishes, in turn through the same subtractor. The result strobe comes in
// the cycle busy falls, and a new item may be accepted in that cycle; no stall.
// Synchronous reset empties the queue, zeroes the clock and selects FIFO policy.
module tick_based_cpu_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [tbcs_pkg::ID_W-1:0]         req_task_id,
   input  logic [tbcs_pkg::REM_W-1:0]        req_burst,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_wdata,
   output logic                              rsp_valid,
   output logic                              rsp_busy_res,
   output logic [tbcs_pkg::ID_W-1:0]         rsp_run_task,
   output logic [tbcs_pkg::REM_W-1:0]        rsp_run_remaining,
   output logic                              rsp_finished,
   output logic [tbcs_pkg::TIME_W-1:0]       rsp_done_time,
   output logic [tbcs_pkg::TIME_W-1:0]       rsp_turnaround,
   output logic [tbcs_pkg::TIME_W-1:0]       rsp_wait_span,
   output logic [tbcs_pkg::TIME_W-1:0]       rsp_time_now,
   output logic                              rsp_queue_full
);
   import tbcs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ARR  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_INS  = 3'd3;
   localparam logic [2:0] ST_ROT  = 3'd4;
   localparam logic [2:0] ST_RUN  = 3'd5;
   localparam logic [2:0] ST_TURN = 3'd6;
   localparam logic [2:0] ST_WAIT = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        policy_ff, policy_in;
   logic              op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [REM_W-1:0]  svc_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic              hrl_ff, hrl_in;
   logic [TIME_W-1:0] done_ff, done_in;
   logic [TIME_W-1:0] turn_ff, turn_in;
   logic [TIME_W-1:0] arrival_ff [16];
   logic [REM_W-1:0]  service_ff [16];
   logic              rec_we;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_busy_res_ff, rsp_busy_res_in;
   logic [ID_W-1:0]   rsp_run_task_ff, rsp_run_task_in;
   logic [REM_W-1:0]  rsp_run_remaining_ff, rsp_run_remaining_in;
   logic              rsp_finished_ff, rsp_finished_in;
   logic [TIME_W-1:0] rsp_done_time_ff, rsp_done_time_in;
   logic [TIME_W-1:0] rsp_turnaround_ff, rsp_turnaround_in;
   logic [TIME_W-1:0] rsp_wait_span_ff, rsp_wait_span_in;
   logic [TIME_W-1:0] rsp_time_now_ff, rsp_time_now_in;
   logic              rsp_queue_full_ff, rsp_queue_full_in;

   queue_cmd_type     qcmd;
   entry_type         head;
   entry_type         scan_e;
   logic [CNT_W-1:0]  count;
   logic [TIME_W-1:0] alu_a, alu_b, alu_diff;
   logic              alu_borrow;
   logic              head_last;
   logic [TIME_W-1:0] clock_next;

   tbcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (qcmd),
      .rd_idx   (idx_ff[IDX_W-1:0]),
      .head     (head),
      .rd_entry (scan_e),
      .count    (count)
   );

   tbcs_alu u_alu (
      .opa    (alu_a),
      .opb    (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign head_last  = (head.rem[REM_W-1:1] == '0);
   assign clock_next = clock_ff + TIME_W'(1);

   // Operand selection for the shared subtractor.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_SCAN: begin
            alu_a = TIME_W'(svc_ff);
            alu_b = TIME_W'(scan_e.rem);
         end
         ST_RUN: begin
            if (head_last) begin
               alu_a = clock_ff;
               alu_b = '1;
            end else begin
               alu_a = TIME_W'(head.rem);
               alu_b = TIME_W'(1);
            end
         end
         ST_TURN: begin
            alu_a = done_ff;
            alu_b = arrival_ff[head.id];
         end
         ST_WAIT: begin
            alu_a = turn_ff;
            alu_b = TIME_W'(service_ff[head.id]);
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      policy_in  = csr_we ? csr_wdata : policy_ff;
      idx_in     = idx_ff;
      clock_in   = clock_ff;
      hrl_in     = hrl_ff;
      done_in    = done_ff;
      turn_in    = turn_ff;
      rec_we     = 1'b0;
      qcmd.op    = Q_NOP;
      qcmd.pos   = idx_ff[IDX_W-1:0];
      qcmd.data  = '{id: id_ff, rem: svc_ff};

      rsp_valid_in         = 1'b0;
      rsp_busy_res_in      = rsp_busy_res_ff;
      rsp_run_task_in      = rsp_run_task_ff;
      rsp_run_remaining_in = rsp_run_remaining_ff;
      rsp_finished_in      = rsp_finished_ff;
      rsp_done_time_in     = rsp_done_time_ff;
      rsp_turnaround_in    = rsp_turnaround_ff;
      rsp_wait_span_in     = rsp_wait_span_ff;
      rsp_time_now_in      = rsp_time_now_ff;
      rsp_queue_full_in    = rsp_queue_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op == OP_ARRIVE) ? ST_ARR : ST_ROT;
            end
         end
         ST_ARR: begin
            if (count == CNT_W'(MAX_TASKS)) begin
               rsp_valid_in         = 1'b1;
               rsp_busy_res_in      = 1'b0;
               rsp_run_task_in      = '0;
               rsp_run_remaining_in = '0;
               rsp_finished_in      = 1'b0;
               rsp_done_time_in     = '0;
               rsp_turnaround_in    = '0;
               rsp_wait_span_in     = '0;
               rsp_time_now_in      = clock_ff;
               rsp_queue_full_in    = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               rec_we = 1'b1;
               if (policy_ff == POL_SRTF) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  idx_in   = count;
                  state_in = ST_INS;
               end
            end
         end
         ST_SCAN: begin
            // Walk past every entry whose remaining time is at most the new one.
            if (idx_ff < count && !alu_borrow) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            qcmd.op              = Q_INSERT;
            rsp_valid_in         = 1'b1;
            rsp_busy_res_in      = 1'b0;
            rsp_run_task_in      = '0;
            rsp_run_remaining_in = '0;
            rsp_finished_in      = 1'b0;
            rsp_done_time_in     = '0;
            rsp_turnaround_in    = '0;
            rsp_wait_span_in     = '0;
            rsp_time_now_in      = clock_ff;
            rsp_queue_full_in    = 1'b0;
            state_in             = ST_IDLE;
         end
         ST_ROT: begin
            // Round robin sends the task that ran last tick to the tail first.
            if (policy_ff == POL_RR && hrl_ff && count > CNT_W'(1)) begin
               qcmd.op = Q_ROTATE;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rsp_done_time_in  = '0;
            rsp_turnaround_in = '0;
            rsp_wait_span_in  = '0;
            rsp_finished_in   = 1'b0;
            rsp_time_now_in   = clock_ff;
            rsp_queue_full_in = 1'b0;
            if (count == '0) begin
               rsp_valid_in         = 1'b1;
               rsp_busy_res_in      = 1'b0;
               rsp_run_task_in      = '0;
               rsp_run_remaining_in = '0;
               hrl_in               = 1'b0;
               clock_in             = clock_next;
               state_in             = ST_IDLE;
            end else if (head_last) begin
               done_in  = alu_diff;
               state_in = ST_TURN;
            end else begin
               qcmd.op              = Q_SETHEAD;
               qcmd.data.rem        = alu_diff[REM_W-1:0];
               rsp_valid_in         = 1'b1;
               rsp_busy_res_in      = 1'b1;
               rsp_run_task_in      = head.id;
               rsp_run_remaining_in = head.rem;
               hrl_in               = (policy_ff == POL_RR);
               clock_in             = clock_next;
               state_in             = ST_IDLE;
            end
         end
         ST_TURN: begin
            turn_in  = alu_diff;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            qcmd.op              = Q_DROP;
            rsp_valid_in         = 1'b1;
            rsp_busy_res_in      = 1'b1;
            rsp_run_task_in      = head.id;
            rsp_run_remaining_in = head.rem;
            rsp_finished_in      = 1'b1;
            rsp_done_time_in     = done_ff;
            rsp_turnaround_in    = turn_ff;
            rsp_wait_span_in     = alu_diff;
            rsp_time_now_in      = clock_ff;
            rsp_queue_full_in    = 1'b0;
            hrl_in               = 1'b0;
            clock_in             = clock_next;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= '0;
         clock_ff     <= '0;
         hrl_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         clock_ff     <= clock_in;
         hrl_ff       <= hrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and working registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff  <= req_op;
         id_ff  <= req_task_id;
         svc_ff <= req_burst;
      end
      idx_ff  <= idx_in;
      done_ff <= done_in;
      turn_ff <= turn_in;
      rsp_busy_res_ff      <= rsp_busy_res_in;
      rsp_run_task_ff      <= rsp_run_task_in;
      rsp_run_remaining_ff <= rsp_run_remaining_in;
      rsp_finished_ff      <= rsp_finished_in;
      rsp_done_time_ff     <= rsp_done_time_in;
      rsp_turnaround_ff    <= rsp_turnaround_in;
      rsp_wait_span_ff     <= rsp_wait_span_in;
      rsp_time_now_ff      <= rsp_time_now_in;
      rsp_queue_full_ff    <= rsp_queue_full_in;
   end

   // Per-task arrival and service records, latest arrival wins.
   always_ff @(posedge clock) begin
      if (rec_we && op_ff == OP_ARRIVE) begin
         arrival_ff[id_ff] <= clock_ff;
         service_ff[id_ff] <= svc_ff;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_busy_res      = rsp_busy_res_ff;
   assign rsp_run_task      = rsp_run_task_ff;
   assign rsp_run_remaining = rsp_run_remaining_ff;
   assign rsp_finished      = rsp_finished_ff;
   assign rsp_done_time     = rsp_done_time_ff;
   assign rsp_turnaround    = rsp_turnaround_ff;
   assign rsp_wait_span     = rsp_wait_span_ff;
   assign rsp_time_now      = rsp_time_now_ff;
   assign rsp_queue_full    = rsp_queue_full_ff;

endmodule

// ===== src/tbcs_checker.sv =====
module tbcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_busy_res,
   input logic rsp_finished,
   input logic rsp_queue_full
);

   // An accepted item makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // The result strobe comes only once the block is idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Every item passes through the idle state, which raises no strobe, so strobes never come back to back.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // A finished task must have run in that tick.
   a_fin_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_busy_res)
      else $error("finish reported without a running task");

   // A rejected arrival never reports a running task.
   a_full_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_full |-> !rsp_busy_res && !rsp_finished)
      else $error("queue full reported together with a run");

endmodule

bind tick_based_cpu_scheduler_unit tbcs_checker u_checker (.*);
